// ===== sv/rmet_pkg.sv =====
// Package: shared constants and a helper function for the rational map escape-time block.
`timescale 1ns / 1ps

package rmet_pkg;

    localparam int QW = 32;
    localparam int NW = 48;
    localparam int CW = 10;

    localparam logic [1:0] OUT_ESCAPED = 2'd0;
    localparam logic [1:0] OUT_ZERO    = 2'd1;
    localparam logic [1:0] OUT_LIMIT   = 2'd2;

    localparam logic [1:0] REG_MULT_RE = 2'd0;
    localparam logic [1:0] REG_MULT_IM = 2'd1;
    localparam logic [1:0] REG_ESC     = 2'd2;
    localparam logic [1:0] REG_ZERO    = 2'd3;

    localparam logic signed [QW-1:0] MULT_RE_RST = 32'sd6171856;
    localparam logic [NW-1:0] ESC_RST  = 48'd42949672960000;
    localparam logic [NW-1:0] ZERO_RST = 48'd429497;

    localparam logic signed [QW-1:0] Q_FOUR    = 32'sh0400_0000;
    localparam logic signed [QW-1:0] Q_QUARTER = 32'sh0040_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [QW-1:0] sat32(input logic signed [66:0] v);
        logic signed [66:0] hi;
        logic signed [66:0] lo;
        hi = 67'sd2147483647;
        lo = -67'sd2147483648;
        if (v > hi) return 32'sh7fff_ffff;
        else if (v < lo) return 32'sh8000_0000;
        else return v[QW-1:0];
    endfunction

endpackage

// ===== sv/rational_map_escape_time.sv =====
// Top level: escape-time iteration of x -> a*x^2*(x-4)/(1-4x).
`timescale 1ns / 1ps

// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: start_re[31:0], start_im[63:32], iter_limit[73:64]
// m_axis   | out       | tdata: iterations[9:0], outcome[11:10]
// cfg      | in        | cfg_index selects mult_re, mult_im, escape_norm, zero_norm
//
// One map step runs its products in sequence on the shared multiplier, then two
// divides; a step that hits a zero denominator ends before the divides. A new
// item is accepted only in the idle state, after the previous result is registered.
// The shared 33x33 multiplier and the bit-serial divider set the pace of a step.
// Reset clears the sequencer and loads the register defaults. A stalled result
// holds in the output register while the next input beat is already accepted.

module rational_map_escape_time #(
    parameter int ITER_CAP = 1023
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // start_re, start_im, iter_limit, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // iterations, outcome, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import rmet_pkg::*;

    localparam int LW = (ITER_CAP > 1023) ? 17 : 10;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_NORM = 5'd1;
    localparam logic [4:0] S_TEST = 5'd2;
    localparam logic [4:0] S_SQ   = 5'd3;   // x*x
    localparam logic [4:0] S_TA   = 5'd4;   // a*s
    localparam logic [4:0] S_NU   = 5'd5;   // t*(x-4)
    localparam logic [4:0] S_DN   = 5'd6;   // |d|^2
    localparam logic [4:0] S_PR   = 5'd7;   // num*conj(d) partial products
    localparam logic [4:0] S_DV0  = 5'd8;
    localparam logic [4:0] S_DW0  = 5'd9;
    localparam logic [4:0] S_DV1  = 5'd10;
    localparam logic [4:0] S_DW1  = 5'd11;
    localparam logic [4:0] S_FIN  = 5'd12;
    localparam logic [4:0] S_OUT  = 5'd13;

    // Configuration registers; the user must write them only while idle, the block does not enforce it.
    logic signed [31:0] mre_reg, mim_reg;
    logic [47:0]        esc_reg, zro_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mre_reg <= MULT_RE_RST;
            mim_reg <= '0;
            esc_reg <= ESC_RST;
            zro_reg <= ZERO_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MULT_RE: mre_reg <= cfg_data[31:0];
                REG_MULT_IM: mim_reg <= cfg_data[31:0];
                REG_ESC:     esc_reg <= cfg_data;
                REG_ZERO:    zro_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic [4:0]  st_reg;
    logic [1:0]  ph_reg;          // partial product index within a step
    logic [LW-1:0] lim_reg, cnt_reg;
    logic        inf_reg;
    logic signed [31:0] xr_reg, xi_reg, ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [31:0] rr_reg, ri_reg, dr_reg, di_reg;
    logic signed [66:0] acc_reg;
    logic signed [66:0] p1_reg;
    logic [63:0] dn_reg;
    logic [47:0] nv_reg;
    logic        ovld_reg;
    logic [9:0]  oit_reg;
    logic [1:0]  oc_reg;

    // Shared multiplier: one 33x33 signed product per cycle.
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [66:0] prodq;    // floored Q8.24 product
    assign prod  = ma * mb;
    assign prodq = 67'(prod >>> 24);

    always_comb
    begin
        ma = 33'(ar_reg);
        mb = 33'(br_reg);
        unique case (ph_reg)
            2'd0: begin ma = 33'(ar_reg); mb = 33'(br_reg); end
            2'd1: begin ma = 33'(ai_reg); mb = 33'(bi_reg); end
            2'd2: begin ma = 33'(ar_reg); mb = 33'(bi_reg); end
            2'd3: begin ma = 33'(ai_reg); mb = 33'(br_reg); end
            default: ;
        endcase
        if (st_reg == S_DN || st_reg == S_NORM)
        begin
            ma = (ph_reg[0]) ? 33'(bi_reg) : 33'(br_reg);
            mb = ma;
        end
    end

    // Divider feed.
    logic        dv_start;
    logic [64:0] dv_mag;
    logic        dv_neg;
    logic        dv_done;
    logic signed [31:0] dv_q;
    logic signed [66:0] sum;
    assign sum    = acc_reg;
    assign dv_neg = sum[66];
    assign dv_mag = sum[66] ? 65'(-sum) : 65'(sum);

    rmet_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .mag   (dv_mag),
        .neg   (dv_neg),
        .den   (dn_reg),
        .done  (dv_done),
        .quo   (dv_q)
    );

    assign dv_start = (st_reg == S_DV0) || (st_reg == S_DV1);
    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {4'd0, oc_reg, oit_reg};

    logic [LW-1:0] in_lim;
    always_comb
    begin
        in_lim = LW'(s_axis_tdata[73:64]);
        if (in_lim > LW'(ITER_CAP))
            in_lim = LW'(ITER_CAP);
    end

    logic signed [31:0] xm4, dq;
    assign xm4 = sat32(67'(xr_reg) - 67'(Q_FOUR));
    assign dq  = sat32(67'(Q_QUARTER) - 67'(xr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            ph_reg   <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            if (ovld_reg && m_axis_tready && st_reg != S_FIN)
                ovld_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        xr_reg  <= s_axis_tdata[31:0];
                        xi_reg  <= s_axis_tdata[63:32];
                        lim_reg <= in_lim;
                        cnt_reg <= '0;
                        inf_reg <= 1'b0;
                        br_reg  <= s_axis_tdata[31:0];
                        bi_reg  <= s_axis_tdata[63:32];
                        ph_reg  <= 2'd0;
                        st_reg  <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    // |x|^2 over two squares of the multiplier
                    if (ph_reg == 2'd0)
                    begin
                        p1_reg <= 67'(prod);
                        ph_reg <= 2'd1;
                    end
                    else
                    begin
                        nv_reg <= 48'((p1_reg + 67'(prod)) >>> 16);
                        ph_reg <= 2'd0;
                        st_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (cnt_reg >= lim_reg || inf_reg ||
                        !(nv_reg < esc_reg && nv_reg > zro_reg))
                        st_reg <= S_FIN;
                    else
                    begin
                        ar_reg <= xr_reg; ai_reg <= xi_reg;
                        br_reg <= xr_reg; bi_reg <= xi_reg;
                        ph_reg <= 2'd0;
                        st_reg <= S_SQ;
                    end
                end
                S_SQ, S_TA, S_NU:
                begin
                    // complex product from four partial products on the shared multiplier
                    ph_reg <= ph_reg + 2'd1;
                    unique case (ph_reg)
                        2'd0: acc_reg <= prodq;
                        2'd1:
                        begin
                            rr_reg <= sat32(acc_reg - prodq);
                        end
                        2'd2: acc_reg <= prodq;
                        2'd3:
                        begin
                            ri_reg <= sat32(acc_reg + prodq);
                            if (st_reg == S_SQ)
                            begin
                                ar_reg <= mre_reg; ai_reg <= mim_reg;
                                br_reg <= rr_reg;
                                bi_reg <= sat32(acc_reg + prodq);
                                st_reg <= S_TA;
                            end
                            else if (st_reg == S_TA)
                            begin
                                ar_reg <= rr_reg;
                                ai_reg <= sat32(acc_reg + prodq);
                                br_reg <= xm4; bi_reg <= xi_reg;
                                st_reg <= S_NU;
                            end
                            else
                            begin
                                dr_reg <= dq;
                                di_reg <= sat32(-67'(xi_reg));
                                br_reg <= dq;
                                bi_reg <= sat32(-67'(xi_reg));
                                st_reg <= S_DN;
                            end
                        end
                        default: ;
                    endcase
                end
                S_DN:
                begin
                    if (dr_reg == 0 && di_reg == 0)
                    begin
                        inf_reg <= 1'b1;
                        cnt_reg <= cnt_reg + LW'(1);
                        st_reg  <= S_TEST;
                    end
                    else if (ph_reg == 2'd0)
                    begin
                        p1_reg <= 67'(prod);
                        ph_reg <= 2'd1;
                    end
                    else
                    begin
                        dn_reg <= 64'(p1_reg + 67'(prod));
                        ar_reg <= rr_reg; ai_reg <= ri_reg;
                        br_reg <= dr_reg; bi_reg <= di_reg;
                        ph_reg <= 2'd0;
                        st_reg <= S_PR;
                    end
                end
                S_PR:
                begin
                    // nr*dr + ni*di for the real part, ni*dr - nr*di later
                    if (ph_reg == 2'd0)
                    begin
                        acc_reg <= 67'(prod);
                        ph_reg  <= 2'd1;
                    end
                    else
                    begin
                        acc_reg <= acc_reg + 67'(prod);
                        st_reg  <= S_DV0;
                        ph_reg  <= 2'd2;
                    end
                end
                S_DV0: st_reg <= S_DW0;
                S_DW0:
                begin
                    if (ph_reg == 2'd3)
                    begin
                        acc_reg <= acc_reg + 67'(prod);  // + ni*dr
                        st_reg  <= S_DV1;
                    end
                    else if (dv_done)
                    begin
                        xr_reg  <= dv_q;
                        acc_reg <= -67'(prod);  // -(nr*di)
                        ph_reg  <= 2'd3;
                    end
                end
                S_DV1: st_reg <= S_DW1;
                S_DW1:
                begin
                    if (dv_done)
                    begin
                        xi_reg  <= dv_q;
                        br_reg  <= xr_reg; bi_reg <= dv_q;
                        cnt_reg <= cnt_reg + LW'(1);
                        ph_reg  <= 2'd0;
                        st_reg  <= S_NORM;
                    end
                end
                S_FIN:
                begin
                    // hold until the previous result is taken
                    if (!ovld_reg || m_axis_tready)
                    begin
                        ovld_reg <= 1'b1;
                        oit_reg  <= cnt_reg[9:0];
                        if (cnt_reg >= lim_reg)
                            oc_reg <= OUT_LIMIT;
                        else if (!inf_reg && nv_reg < zro_reg)
                            oc_reg <= OUT_ZERO;
                        else
                            oc_reg <= OUT_ESCAPED;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/rmet_div.sv =====
// Restoring divider: sign * floor(mag * 2^22 / den), saturated to 32 bits.
`timescale 1ns / 1ps

module rmet_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [64:0]            mag,
    input  logic                   neg,
    input  logic [63:0]            den,
    output logic                   done,
    output logic signed [31:0]     quo
);
    import rmet_pkg::*;

    // Long division over mag*2^22: 87 numerator bits, one per cycle.
    localparam int NB = 87;

    logic [NB-1:0] num_reg, num_next;
    logic [64:0]   rem_reg, rem_next;
    logic [NB-1:0] q_reg, q_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;

    logic [65:0]   trial;
    logic [65:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NB-1]};
        diff      = trial - {2'b0, den};
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = {mag, 22'd0};
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NB-2:0], 1'b0};
            if (!diff[65])
            begin
                rem_next = diff[64:0];
                q_next   = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[64:0];
                q_next   = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    logic signed [66:0] qs;
    always_comb
    begin
        qs = '0;
        if (q_reg[NB-1:31] != '0)
            quo = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
        begin
            qs  = neg_reg ? -$signed({36'd0, q_reg[30:0]}) : $signed({36'd0, q_reg[30:0]});
            quo = sat32(qs);
        end
    end

    assign done = done_reg;

endmodule
